// ===== sv/mpow_pkg.sv =====
// Shared types, constants and the control program of the modular power block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package mpow_pkg;

  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned PC_W           = 4;

  typedef logic [PC_W-1:0] mpow_pc_t;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_ONE,
    OP_SET_ERR,
    OP_RED_INIT,
    OP_MSTEP,
    OP_BASE_SAVE,
    OP_SQ_INIT,
    OP_MUL_INIT,
    OP_RES_NEXT,
    OP_EMIT
  } mpow_op_t;

  // Jump conditions; a true condition loads the target, otherwise the step counter advances.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_REQ,
    C_EXP_ZERO,
    C_MOD_ZERO,
    C_CNT_NZ,
    C_EBIT_CLR,
    C_ECNT_NZ,
    C_OUT_BUSY
  } mpow_cond_t;

  typedef struct packed {
    mpow_op_t   op;
    mpow_cond_t cond;
    mpow_pc_t   target;
  } mpow_ucode_t;

  typedef struct packed {
    mpow_op_t op;
  } mpow_ctrl_t;

  typedef struct packed {
    logic exp_zero;
    logic mod_zero;
    logic cnt_nz;
    logic ebit;
    logic ecnt_nz;
  } mpow_stat_t;

  // Program addresses.
  localparam mpow_pc_t PC_WAIT     = 4'd0;
  localparam mpow_pc_t PC_ONE      = 4'd1;
  localparam mpow_pc_t PC_ZMOD     = 4'd2;
  localparam mpow_pc_t PC_RED      = 4'd3;
  localparam mpow_pc_t PC_RED_LOOP = 4'd4;
  localparam mpow_pc_t PC_BSAVE    = 4'd5;
  localparam mpow_pc_t PC_SQ       = 4'd6;
  localparam mpow_pc_t PC_SQ_LOOP  = 4'd7;
  localparam mpow_pc_t PC_TEST     = 4'd8;
  localparam mpow_pc_t PC_MUL      = 4'd9;
  localparam mpow_pc_t PC_MUL_LOOP = 4'd10;
  localparam mpow_pc_t PC_RES      = 4'd11;
  localparam mpow_pc_t PC_EMIT     = 4'd12;
  localparam mpow_pc_t PC_BACK     = 4'd13;

  // The control program. Each multiply is one modular shift-and-add step per multiplier bit.
  function automatic mpow_ucode_t ucode_rom(input mpow_pc_t pc);
    mpow_ucode_t w;
    unique case (pc)
      PC_WAIT:     w = '{op: OP_LOAD,      cond: C_NO_REQ,   target: PC_WAIT};
      PC_ONE:      w = '{op: OP_SET_ONE,   cond: C_EXP_ZERO, target: PC_EMIT};
      PC_ZMOD:     w = '{op: OP_SET_ERR,   cond: C_MOD_ZERO, target: PC_EMIT};
      PC_RED:      w = '{op: OP_RED_INIT,  cond: C_ALWAYS,   target: PC_RED_LOOP};
      PC_RED_LOOP: w = '{op: OP_MSTEP,     cond: C_CNT_NZ,   target: PC_RED_LOOP};
      PC_BSAVE:    w = '{op: OP_BASE_SAVE, cond: C_ALWAYS,   target: PC_SQ};
      PC_SQ:       w = '{op: OP_SQ_INIT,   cond: C_ALWAYS,   target: PC_SQ_LOOP};
      PC_SQ_LOOP:  w = '{op: OP_MSTEP,     cond: C_CNT_NZ,   target: PC_SQ_LOOP};
      PC_TEST:     w = '{op: OP_NONE,      cond: C_EBIT_CLR, target: PC_RES};
      PC_MUL:      w = '{op: OP_MUL_INIT,  cond: C_ALWAYS,   target: PC_MUL_LOOP};
      PC_MUL_LOOP: w = '{op: OP_MSTEP,     cond: C_CNT_NZ,   target: PC_MUL_LOOP};
      PC_RES:      w = '{op: OP_RES_NEXT,  cond: C_ECNT_NZ,  target: PC_SQ};
      PC_EMIT:     w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: PC_EMIT};
      PC_BACK:     w = '{op: OP_NONE,      cond: C_ALWAYS,   target: PC_WAIT};
      default:     w = '{op: OP_NONE,      cond: C_ALWAYS,   target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/mpow_if.sv =====
// Valid/ready channel interfaces for the request and result sides of modular_power.
// Depends on mpow_pkg for the default word width.
interface mpow_in_if #(
  parameter int unsigned W = mpow_pkg::WORD_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] base;
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;

  modport source (output valid, base, exponent, modulus, input ready);
  modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

interface mpow_out_if #(
  parameter int unsigned W = mpow_pkg::WORD_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] power_result;
  logic         zero_modulus_error;

  modport source (output valid, power_result, zero_modulus_error, input ready);
  modport sink   (input valid, power_result, zero_modulus_error, output ready);
endinterface

// ===== sv/mpow_dp.sv =====
// Datapath of modular_power: operand registers, counters and the modular shift-and-add unit.
// Depends on mpow_pkg for the control and status structs.
module mpow_dp #(
  parameter int unsigned WORD_WIDTH = mpow_pkg::WORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  mpow_pkg::mpow_ctrl_t   ctrl,
  input  logic [WORD_WIDTH-1:0]  base,
  input  logic [WORD_WIDTH-1:0]  exponent,
  input  logic [WORD_WIDTH-1:0]  modulus,
  output mpow_pkg::mpow_stat_t   stat,
  output logic [WORD_WIDTH-1:0]  result,
  output logic                   err
);

  localparam int unsigned CNT_W = $clog2(WORD_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

  logic [WORD_WIDTH-1:0] m_r, exp_r, base_r, res_r, prod_r, mcand_r, mplier_r;
  logic                  err_r;
  logic [CNT_W-1:0]      cnt_r, ecnt_r;

  logic [WORD_WIDTH-1:0] addend;
  logic [WORD_WIDTH+1:0] sum, m1, m2, d1, d2;
  logic [WORD_WIDTH-1:0] step;

  // One step: (2*prod + addend) mod m, where the sum stays below three times m.
  always_comb begin
    addend = mplier_r[WORD_WIDTH-1] ? mcand_r : '0;
    sum    = {1'b0, prod_r, 1'b0} + {2'b00, addend};
    m1     = {2'b00, m_r};
    m2     = {1'b0, m_r, 1'b0};
    d1     = sum - m1;
    d2     = sum - m2;
    if (sum >= m2) begin
      step = d2[WORD_WIDTH-1:0];
    end else if (sum >= m1) begin
      step = d1[WORD_WIDTH-1:0];
    end else begin
      step = sum[WORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      mpow_pkg::OP_LOAD: begin
        m_r    <= modulus;
        exp_r  <= exponent;
        base_r <= base;
      end
      mpow_pkg::OP_SET_ONE: begin
        res_r <= WORD_WIDTH'(1);
        err_r <= 1'b0;
      end
      mpow_pkg::OP_SET_ERR: begin
        res_r <= '0;
        err_r <= 1'b1;
      end
      mpow_pkg::OP_RED_INIT: begin
        prod_r   <= '0;
        mcand_r  <= WORD_WIDTH'(1);
        mplier_r <= base_r;
        cnt_r    <= CNT_LAST;
      end
      mpow_pkg::OP_MSTEP: begin
        prod_r   <= step;
        mplier_r <= {mplier_r[WORD_WIDTH-2:0], 1'b0};
        cnt_r    <= cnt_r - 1'b1;
      end
      mpow_pkg::OP_BASE_SAVE: begin
        base_r <= prod_r;
        res_r  <= (m_r == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
        err_r  <= 1'b0;
        ecnt_r <= CNT_LAST;
      end
      mpow_pkg::OP_SQ_INIT: begin
        prod_r   <= '0;
        mcand_r  <= res_r;
        mplier_r <= res_r;
        cnt_r    <= CNT_LAST;
      end
      mpow_pkg::OP_MUL_INIT: begin
        // The squared value is still in the accumulator.
        prod_r   <= '0;
        mcand_r  <= prod_r;
        mplier_r <= base_r;
        cnt_r    <= CNT_LAST;
      end
      mpow_pkg::OP_RES_NEXT: begin
        res_r  <= prod_r;
        exp_r  <= {exp_r[WORD_WIDTH-2:0], 1'b0};
        ecnt_r <= ecnt_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.exp_zero = (exp_r == '0);
    stat.mod_zero = (m_r == '0);
    stat.cnt_nz   = (cnt_r != '0);
    stat.ebit     = exp_r[WORD_WIDTH-1];
    stat.ecnt_nz  = (ecnt_r != '0);
  end

  assign result = res_r;
  assign err    = err_r;

endmodule

// ===== sv/modular_power.sv =====
// A zero exponent, checked first, gives a result of one and a zero modulus sets the error;
// otherwise the base is reduced mod the modulus, then for each of the W exponent bits, from
// the top, the result is squared and, for a one bit, multiplied by the base.
// After loading the output, the sequencer takes a return step before it takes a new request.
// The shared modular shift-and-add unit handles one multiplier bit per cycle.
// Synchronous active-low reset returns the sequencer to its wait step and empties the output.
module modular_power #(
  parameter int unsigned WORD_WIDTH = mpow_pkg::WORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mpow_in_if.sink    in_chan,
  mpow_out_if.source out_chan
);

  // Step counter of the control program and the fetched control word.
  mpow_pkg::mpow_pc_t    pc_r, pc_nxt;
  mpow_pkg::mpow_ucode_t uc;

  mpow_pkg::mpow_ctrl_t  ctrl;
  mpow_pkg::mpow_stat_t  stat;

  logic                  accept;
  logic                  out_busy;
  logic                  emit_ld;
  logic                  take;

  logic [WORD_WIDTH-1:0] dp_result;
  logic                  dp_err;

  // Output register: a finished result waits here while the sequencer returns for the next
  // request.
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_WIDTH-1:0] out_result_r;
  logic                  out_err_r;

  assign uc       = mpow_pkg::ucode_rom(pc_r);
  assign out_busy = out_valid_r && !out_chan.ready;
  assign accept   = in_chan.valid && in_chan.ready;

  // Control outputs decoded from the current control word. No request is taken while
  // reset is held.
  always_comb begin
    in_chan.ready = (uc.op == mpow_pkg::OP_LOAD) && rst_n;
    ctrl.op       = uc.op;
    if ((uc.op == mpow_pkg::OP_LOAD) && !in_chan.valid) begin
      ctrl.op = mpow_pkg::OP_NONE;
    end
    emit_ld = (uc.op == mpow_pkg::OP_EMIT) && !out_busy;
  end

  // Next step: jump to the target when the condition holds, otherwise fall through.
  always_comb begin
    unique case (uc.cond)
      mpow_pkg::C_ALWAYS:   take = 1'b1;
      mpow_pkg::C_NO_REQ:   take = !accept;
      mpow_pkg::C_EXP_ZERO: take = stat.exp_zero;
      mpow_pkg::C_MOD_ZERO: take = stat.mod_zero;
      mpow_pkg::C_CNT_NZ:   take = stat.cnt_nz;
      mpow_pkg::C_EBIT_CLR: take = !stat.ebit;
      mpow_pkg::C_ECNT_NZ:  take = stat.ecnt_nz;
      mpow_pkg::C_OUT_BUSY: take = out_busy;
      default:              take = 1'b1;
    endcase
    pc_nxt = take ? uc.target : pc_r + 1'b1;
  end

  always_comb begin
    if (emit_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mpow_pkg::PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ld) begin
      out_result_r <= dp_result;
      out_err_r    <= dp_err;
    end
  end

  mpow_dp #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .base     (in_chan.base),
    .exponent (in_chan.exponent),
    .modulus  (in_chan.modulus),
    .stat     (stat),
    .result   (dp_result),
    .err      (dp_err)
  );

  assign out_chan.valid              = out_valid_r;
  assign out_chan.power_result       = out_result_r;
  assign out_chan.zero_modulus_error = out_err_r;

endmodule

// ===== sv/mpow_checker.sv =====
// Port-level assertions for modular_power, attached to every instance by the bind below.
// Depends on mpow_pkg for the default word width and on the top level's channel ports.
module mpow_checker #(
  parameter int unsigned W = mpow_pkg::WORD_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] power_result,
  input logic         zero_modulus_error
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(power_result)
                                && $stable(zero_modulus_error))
    else $error("result changed while stalled");

  // A zero modulus error always comes with a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_modulus_error |-> power_result == '0)
    else $error("error flag with nonzero result");

  // Only one request is in work at a time.
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // No result appears in the cycle right after a request is taken.
  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind modular_power mpow_checker #(
  .W(WORD_WIDTH)
) u_mpow_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .power_result       (out_chan.power_result),
  .zero_modulus_error (out_chan.zero_modulus_error)
);
